// ===== src/assert_macros.svh =====
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define HSV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every clock edge, reset included
`define HSV_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== src/hsvrgb_pkg.sv =====
`timescale 1ns / 1ps

package hsvrgb_pkg;

    localparam int PCT_FULL     = 100;
    localparam int SECTOR_DEG   = 60;
    localparam int SECTOR_COUNT = 6;
    localparam int CHAN_MAX     = 255;
    localparam int HUE_WRAP     = SECTOR_DEG * SECTOR_COUNT;

    // number of register stages end to end
    localparam int PIPE_DEPTH   = 9;

    // reciprocals: floor(x * RECIP >> SHIFT) == floor(x / d) over the used range
    localparam int  RECIP360_SHIFT = 32;
    localparam longint RECIP360    = ((64'd1 << RECIP360_SHIFT) + HUE_WRAP - 1) / HUE_WRAP;
    localparam int  RECIP60_SHIFT  = 24;
    localparam longint RECIP60     = ((64'd1 << RECIP60_SHIFT) + SECTOR_DEG - 1) / SECTOR_DEG;
    localparam int  RECIP100_SHIFT = 28;
    localparam longint RECIP100    = ((64'd1 << RECIP100_SHIFT) + PCT_FULL - 1) / PCT_FULL;

    typedef logic [6:0]  pct_t;
    typedef logic [7:0]  chan_t;
    typedef logic [15:0] hue_t;

    typedef enum logic [2:0] {
        SEC_R_TO_Y = 3'd0,
        SEC_Y_TO_G = 3'd1,
        SEC_G_TO_C = 3'd2,
        SEC_C_TO_B = 3'd3,
        SEC_B_TO_M = 3'd4,
        SEC_M_TO_R = 3'd5
    } sector_t;

    typedef struct packed {
        sector_t    sector;
        logic [5:0] frac;
        pct_t       sat;
        pct_t       val;
    } hue_res_t;

    typedef struct packed {
        sector_t sector;
        pct_t    val;
        pct_t    p;
        pct_t    q;
        pct_t    t;
    } pqt_t;

    // floor(h / 360) for any 16-bit h
    function automatic logic [7:0] div360(input hue_t h);
        logic [39:0] prod;
        prod = {24'd0, h} * 40'(RECIP360);
        return prod[39:32];
    endfunction

    // floor(x / 60) for x up to 6000
    function automatic pct_t div60(input logic [12:0] x);
        logic [31:0] prod;
        prod = {19'd0, x} * 32'(RECIP60);
        return prod[30:24];
    endfunction

    // floor(x / 100) for x up to 25500
    function automatic chan_t div100(input logic [14:0] x);
        logic [36:0] prod;
        prod = {22'd0, x} * 37'(RECIP100);
        return prod[35:28];
    endfunction

    function automatic pct_t clamp_pct(input pct_t x);
        return (x > pct_t'(PCT_FULL)) ? pct_t'(PCT_FULL) : x;
    endfunction

    // sector of a hue already reduced below 360
    function automatic sector_t sector_of(input logic [8:0] hm);
        sector_t sec;
        if (hm >= 9'(5 * SECTOR_DEG)) begin
            sec = SEC_M_TO_R;
        end else if (hm >= 9'(4 * SECTOR_DEG)) begin
            sec = SEC_B_TO_M;
        end else if (hm >= 9'(3 * SECTOR_DEG)) begin
            sec = SEC_C_TO_B;
        end else if (hm >= 9'(2 * SECTOR_DEG)) begin
            sec = SEC_G_TO_C;
        end else if (hm >= 9'(SECTOR_DEG)) begin
            sec = SEC_Y_TO_G;
        end else begin
            sec = SEC_R_TO_Y;
        end
        return sec;
    endfunction

endpackage

// ===== src/hsvrgb_hue.sv =====
`timescale 1ns / 1ps

module hsvrgb_hue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  hsvrgb_pkg::hue_t      hue,
    input  hsvrgb_pkg::pct_t      saturation,
    input  hsvrgb_pkg::pct_t      brightness,
    output logic                  out_valid,
    input  logic                  out_ready,
    output hsvrgb_pkg::hue_res_t  out_data
);
    import hsvrgb_pkg::*;

    logic vld1_reg, vld2_reg, vld3_reg;
    logic rdy1, rdy2, rdy3;

    hue_t       h1_reg;
    logic [7:0] quo1_reg;
    pct_t       s1_reg, v1_reg;
    logic [8:0] hm2_reg;
    pct_t       s2_reg, v2_reg;
    hue_res_t   res3_reg;

    logic [15:0] wrap_sub;
    logic [8:0]  hm_next;
    sector_t     sec_next;
    logic [8:0]  base_deg;
    hue_res_t    res3_next;

    assign rdy3     = !vld3_reg || out_ready;
    assign rdy2     = !vld2_reg || rdy3;
    assign rdy1     = !vld1_reg || rdy2;
    assign in_ready = rdy1;

    // hue minus whole turns
    assign wrap_sub = h1_reg - 16'(quo1_reg) * 16'(HUE_WRAP);
    assign hm_next  = wrap_sub[8:0];

    always_comb begin
        sec_next          = sector_of(hm2_reg);
        base_deg          = 9'(sec_next) * 9'(SECTOR_DEG);
        res3_next.sector  = sec_next;
        res3_next.frac    = 6'(hm2_reg - base_deg);
        res3_next.sat     = s2_reg;
        res3_next.val     = v2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end else begin
            if (rdy1) vld1_reg <= in_valid;
            if (rdy2) vld2_reg <= vld1_reg;
            if (rdy3) vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            h1_reg   <= hue;
            quo1_reg <= div360(hue);
            s1_reg   <= clamp_pct(saturation);
            v1_reg   <= clamp_pct(brightness);
        end
        if (rdy2 && vld1_reg) begin
            hm2_reg <= hm_next;
            s2_reg  <= s1_reg;
            v2_reg  <= v1_reg;
        end
        if (rdy3 && vld2_reg) begin
            res3_reg <= res3_next;
        end
    end

    assign out_valid = vld3_reg;
    assign out_data  = res3_reg;

endmodule

// ===== src/hsvrgb_pqt.sv =====
`timescale 1ns / 1ps

module hsvrgb_pqt (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  hsvrgb_pkg::hue_res_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output hsvrgb_pkg::pqt_t      out_data
);
    import hsvrgb_pkg::*;

    logic vld1_reg, vld2_reg, vld3_reg, vld4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    // stage 1: s * f and s * (60 - f)
    logic [12:0] sf1_reg, sr1_reg;
    sector_t     sec1_reg, sec2_reg, sec3_reg;
    pct_t        s1_reg, v1_reg, v2_reg;
    // stage 2: percentages left after the cuts
    pct_t        pa2_reg, qa2_reg, ta2_reg;
    // stage 3: v times those
    logic [13:0] vp3_reg, vq3_reg, vt3_reg;
    pct_t        v3_reg;
    pqt_t        res4_reg;

    logic [5:0]  frac_rest;
    pqt_t        res4_next;

    assign rdy4     = !vld4_reg || out_ready;
    assign rdy3     = !vld3_reg || rdy4;
    assign rdy2     = !vld2_reg || rdy3;
    assign rdy1     = !vld1_reg || rdy2;
    assign in_ready = rdy1;

    assign frac_rest = 6'(SECTOR_DEG) - in_data.frac;

    always_comb begin
        res4_next.sector = sec3_reg;
        res4_next.val    = v3_reg;
        res4_next.p      = pct_t'(div100({1'b0, vp3_reg}));
        res4_next.q      = pct_t'(div100({1'b0, vq3_reg}));
        res4_next.t      = pct_t'(div100({1'b0, vt3_reg}));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
        end else begin
            if (rdy1) vld1_reg <= in_valid;
            if (rdy2) vld2_reg <= vld1_reg;
            if (rdy3) vld3_reg <= vld2_reg;
            if (rdy4) vld4_reg <= vld3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            sf1_reg  <= 13'(in_data.sat) * 13'(in_data.frac);
            sr1_reg  <= 13'(in_data.sat) * 13'(frac_rest);
            sec1_reg <= in_data.sector;
            s1_reg   <= in_data.sat;
            v1_reg   <= in_data.val;
        end
        if (rdy2 && vld1_reg) begin
            pa2_reg  <= pct_t'(PCT_FULL) - s1_reg;
            qa2_reg  <= pct_t'(PCT_FULL) - div60(sf1_reg);
            ta2_reg  <= pct_t'(PCT_FULL) - div60(sr1_reg);
            sec2_reg <= sec1_reg;
            v2_reg   <= v1_reg;
        end
        if (rdy3 && vld2_reg) begin
            vp3_reg  <= 14'(v2_reg) * 14'(pa2_reg);
            vq3_reg  <= 14'(v2_reg) * 14'(qa2_reg);
            vt3_reg  <= 14'(v2_reg) * 14'(ta2_reg);
            sec3_reg <= sec2_reg;
            v3_reg   <= v2_reg;
        end
        if (rdy4 && vld3_reg) begin
            res4_reg <= res4_next;
        end
    end

    assign out_valid = vld4_reg;
    assign out_data  = res4_reg;

endmodule

// ===== src/hsvrgb_scale.sv =====
`timescale 1ns / 1ps

module hsvrgb_scale (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  hsvrgb_pkg::pqt_t   in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output hsvrgb_pkg::chan_t  red,
    output hsvrgb_pkg::chan_t  green,
    output hsvrgb_pkg::chan_t  blue
);
    import hsvrgb_pkg::*;

    logic vld1_reg, vld2_reg;
    logic rdy1, rdy2;

    pct_t        r_pct, g_pct, b_pct;
    logic [14:0] r1_reg, g1_reg, b1_reg;
    chan_t       r2_reg, g2_reg, b2_reg;

    assign rdy2     = !vld2_reg || out_ready;
    assign rdy1     = !vld1_reg || rdy2;
    assign in_ready = rdy1;

    // six-sector routing of v, p, q, t
    always_comb begin
        case (in_data.sector)
            SEC_R_TO_Y: begin
                r_pct = in_data.val; g_pct = in_data.t;   b_pct = in_data.p;
            end
            SEC_Y_TO_G: begin
                r_pct = in_data.q;   g_pct = in_data.val; b_pct = in_data.p;
            end
            SEC_G_TO_C: begin
                r_pct = in_data.p;   g_pct = in_data.val; b_pct = in_data.t;
            end
            SEC_C_TO_B: begin
                r_pct = in_data.p;   g_pct = in_data.q;   b_pct = in_data.val;
            end
            SEC_B_TO_M: begin
                r_pct = in_data.t;   g_pct = in_data.p;   b_pct = in_data.val;
            end
            default: begin
                r_pct = in_data.val; g_pct = in_data.p;   b_pct = in_data.q;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end else begin
            if (rdy1) vld1_reg <= in_valid;
            if (rdy2) vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            r1_reg <= 15'(r_pct) * 15'(CHAN_MAX);
            g1_reg <= 15'(g_pct) * 15'(CHAN_MAX);
            b1_reg <= 15'(b_pct) * 15'(CHAN_MAX);
        end
        if (rdy2 && vld1_reg) begin
            r2_reg <= div100(r1_reg);
            g2_reg <= div100(g1_reg);
            b2_reg <= div100(b1_reg);
        end
    end

    assign out_valid = vld2_reg;
    assign red       = r2_reg;
    assign green     = g2_reg;
    assign blue      = b2_reg;

endmodule

// ===== src/hsv_to_rgb_percent.sv =====
// path: a request accepted on s_* reaches its result on m_* through the nine register stages
// throughput: one request per cycle while m_ready stays high, set by nine register stages that each take one
// throughput: each stage holds one request and moves on when the stage after it has room
// reset: aresetn synchronous active low, clears all stage valid bits and the in-flight check counter; no other state
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hsv_to_rgb_percent (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  hsvrgb_pkg::hue_t   s_hue,
    input  hsvrgb_pkg::pct_t   s_saturation,
    input  hsvrgb_pkg::pct_t   s_brightness,
    output logic               m_valid,
    input  logic               m_ready,
    output hsvrgb_pkg::chan_t  m_red,
    output hsvrgb_pkg::chan_t  m_green,
    output hsvrgb_pkg::chan_t  m_blue
);
    import hsvrgb_pkg::*;

    // hue front end -> p/q/t core
    logic     hue_valid, hue_ready;
    hue_res_t hue_data;
    // p/q/t core -> channel routing and scaling
    logic     pqt_valid, pqt_ready;
    pqt_t     pqt_data;

    // requests accepted but not yet delivered, for checking only
    logic [3:0] inflight_reg, inflight_next;
    logic       take_in, take_out;

    // stages 1-3: clamp, reduce hue mod 360, split into sector and offset
    hsvrgb_hue u_hue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .hue        (s_hue),
        .saturation (s_saturation),
        .brightness (s_brightness),
        .out_valid  (hue_valid),
        .out_ready  (hue_ready),
        .out_data   (hue_data)
    );

    // stages 4-7: p, q, t with the truncating divides in the original order
    hsvrgb_pqt u_pqt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (hue_valid),
        .in_ready  (hue_ready),
        .in_data   (hue_data),
        .out_valid (pqt_valid),
        .out_ready (pqt_ready),
        .out_data  (pqt_data)
    );

    // stages 8-9: sector routing, then pct * 255 / 100; stage 9 is the output register
    hsvrgb_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (pqt_valid),
        .in_ready  (pqt_ready),
        .in_data   (pqt_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .red       (m_red),
        .green     (m_green),
        .blue      (m_blue)
    );

    assign take_in  = s_valid && s_ready;
    assign take_out = m_valid && m_ready;

    always_comb begin
        inflight_next = inflight_reg;
        if (take_in && !take_out) begin
            inflight_next = inflight_reg + 4'd1;
        end else if (take_out && !take_in) begin
            inflight_next = inflight_reg - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= 4'd0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    // the output register is empty right after reset
    `HSV_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid, "m_valid set after reset")
    // the pipeline never holds more requests than it has stages
    `HSV_ASSERT(a_depth, inflight_reg <= 4'(PIPE_DEPTH), "more requests in flight than stages")
    // nothing comes out of an empty pipeline
    `HSV_ASSERT(a_no_ghost, inflight_reg == 4'd0 |-> !m_valid, "result with no request in flight")
    // the input stalls only when every stage is full behind a held result
    `HSV_ASSERT(a_stall_src, !s_ready |-> m_valid && !m_ready, "input stalled without back-pressure")

endmodule

// ===== sim/hsv_to_rgb_percent_test.sv =====
`timescale 1ns / 1ps

// checks hsv_to_rgb_percent against its own integer predictor: a directed pass over the
// sector edges, hue wrap and percent clamps, then random requests, with random idling on
// both handshakes and one long back-pressure stretch that fills the pipeline
module hsv_to_rgb_percent_test;
    import hsvrgb_pkg::*;

    // timing of the run
    localparam int unsigned RESET_CYCLES  = 8;
    localparam int unsigned RANDOM_ITEMS  = 400;
    localparam int unsigned MAX_IDLE      = 17;
    localparam int unsigned DRAIN_CYCLES  = 20;     // wait after the drain so a stray pixel can show up
    localparam int unsigned HOLD_AT       = 100;    // result count where the sink stops
    localparam int unsigned HOLD_CYCLES   = 120;    // long enough to fill all stages
    localparam int unsigned BURST_FIRST   = 50;     // random requests sent back to back
    localparam int unsigned BURST_LAST    = 169;
    localparam int unsigned CYCLE_LIMIT   = 200000;

    // one expected pixel
    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } rgb_t;

    // keeps the expected pixels in request order and compares each returned one
    class color_scoreboard;
        rgb_t        pending_q[$];
        int unsigned errors = 0;

        // percent inputs above full scale count as full scale
        static function int unsigned pct_clamp(pct_t x);
            return (x > pct_t'(PCT_FULL)) ? PCT_FULL : int'(x);
        endfunction

        // six-sector hsv conversion with truncating divides in the block's order
        static function rgb_t hsv_color(hue_t h, pct_t sat_in, pct_t bri_in);
            int unsigned sat, bri, f, p, q, t, r, g, b;
            sector_t     sec;
            rgb_t        px;
            sat = pct_clamp(sat_in);
            bri = pct_clamp(bri_in);
            sec = sector_t'((int'(h) / SECTOR_DEG) % SECTOR_COUNT);
            f   = int'(h) % SECTOR_DEG;
            p   = bri * (PCT_FULL - sat) / PCT_FULL;
            q   = bri * (PCT_FULL - (sat * f) / SECTOR_DEG) / PCT_FULL;
            t   = bri * (PCT_FULL - (sat * (SECTOR_DEG - f)) / SECTOR_DEG) / PCT_FULL;
            case (sec)
                SEC_R_TO_Y: begin r = bri; g = t;   b = p;   end
                SEC_Y_TO_G: begin r = q;   g = bri; b = p;   end
                SEC_G_TO_C: begin r = p;   g = bri; b = t;   end
                SEC_C_TO_B: begin r = p;   g = q;   b = bri; end
                SEC_B_TO_M: begin r = t;   g = p;   b = bri; end
                default:    begin r = bri; g = p;   b = q;   end
            endcase
            px.red   = chan_t'(r * CHAN_MAX / PCT_FULL);
            px.green = chan_t'(g * CHAN_MAX / PCT_FULL);
            px.blue  = chan_t'(b * CHAN_MAX / PCT_FULL);
            return px;
        endfunction

        function void note_request(hue_t h, pct_t sat, pct_t bri);
            pending_q.push_back(hsv_color(h, sat, bri));
        endfunction

        function void check_result(chan_t red, chan_t green, chan_t blue);
            rgb_t want;
            if (pending_q.size() == 0) begin
                $error("unexpected pixel: red %0d green %0d blue %0d", red, green, blue);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            if (red !== want.red) begin
                $error("red mismatch: expected %0d, actual %0d", want.red, red);
                errors++;
            end
            if (green !== want.green) begin
                $error("green mismatch: expected %0d, actual %0d", want.green, green);
                errors++;
            end
            if (blue !== want.blue) begin
                $error("blue mismatch: expected %0d, actual %0d", want.blue, blue);
                errors++;
            end
        endfunction

        function int unsigned outstanding();
            return pending_q.size();
        endfunction
    endclass

    // all inputs known from time zero
    logic  aclk         = 1'b0;
    logic  aresetn      = 1'b0;
    logic  s_valid      = 1'b0;
    hue_t  s_hue        = '0;
    pct_t  s_saturation = '0;
    pct_t  s_brightness = '0;
    logic  m_ready      = 1'b0;
    logic  s_ready;
    logic  m_valid;
    chan_t m_red;
    chan_t m_green;
    chan_t m_blue;

    color_scoreboard sb = new();
    int unsigned     cycle_count = 0;

    hsv_to_rgb_percent uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_hue        (s_hue),
        .s_saturation (s_saturation),
        .s_brightness (s_brightness),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red        (m_red),
        .m_green      (m_green),
        .m_blue       (m_blue)
    );

    // 20 ns clock
    always #10 aclk = ~aclk;

    // hard stop if the pipeline hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // reset is held from time zero and released once
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // idle cycles before one request or one result; eager stretches have none
    function automatic int unsigned idle_cycles(bit eager);
        return eager ? 0 : $urandom_range(0, MAX_IDLE);
    endfunction

    // random percent: mostly in range, some clamped values, some exact ends
    function automatic pct_t rand_pct();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 8) begin
            return pct_t'($urandom_range(0, PCT_FULL));
        end else if (pick == 8) begin
            return pct_t'($urandom_range(PCT_FULL + 1, 127));
        end
        return ($urandom_range(0, 1) != 0) ? pct_t'(PCT_FULL) : pct_t'(0);
    endfunction

    // random hue: full 16-bit range, the first two turns, or a sector edge
    function automatic hue_t rand_hue();
        int unsigned pick;
        pick = $urandom_range(0, 3);
        if (pick < 2) begin
            return hue_t'($urandom);
        end else if (pick == 2) begin
            return hue_t'($urandom_range(0, 2 * HUE_WRAP - 1));
        end
        // first or last degree of some sector anywhere in the hue range
        return hue_t'(SECTOR_DEG * $urandom_range(0, 1091)
                      + (($urandom_range(0, 1) != 0) ? SECTOR_DEG - 1 : 0));
    endfunction

    // offer one request after a gap and wait for the block to take it;
    // entered and left at a rising edge, valid stays high across back-to-back requests
    task automatic send_request(hue_t h, pct_t sat, pct_t bri, int unsigned gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_hue        <= h;
        s_saturation <= sat;
        s_brightness <= bri;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(h, sat, bri);
    endtask

    // sink side: random stalls in stretches, plus one long hold-off that backs up
    // the pipeline while the source keeps pushing
    initial begin
        int unsigned results_seen = 0;
        int unsigned stall;
        bit          eager = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (results_seen % 32 == 0) begin
                eager = ($urandom_range(0, 2) == 0);
            end
            if (results_seen == HOLD_AT) begin
                stall = HOLD_CYCLES;
            end else begin
                stall = idle_cycles(eager);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_result(m_red, m_green, m_blue);
            results_seen++;
        end
    end

    // source side and end of run
    initial begin
        bit eager = 1'b0;
        do @(posedge aclk); while (!aresetn);

        // primary and secondary colors at each sector start, then the edges at 359, 59 and 61
        send_request(16'd0,     7'd100, 7'd100, idle_cycles(eager));
        send_request(16'd60,    7'd100, 7'd100, idle_cycles(eager));
        send_request(16'd120,   7'd100, 7'd100, idle_cycles(eager));
        send_request(16'd180,   7'd100, 7'd100, idle_cycles(eager));
        send_request(16'd240,   7'd100, 7'd100, idle_cycles(eager));
        send_request(16'd300,   7'd100, 7'd100, idle_cycles(eager));
        send_request(16'd359,   7'd100, 7'd100, idle_cycles(eager));
        send_request(16'd59,    7'd100, 7'd100, idle_cycles(eager));
        send_request(16'd61,    7'd100, 7'd100, idle_cycles(eager));
        // hue past one turn: sector wraps, f does not
        send_request(16'd360,   7'd100, 7'd100, idle_cycles(eager));
        send_request(16'd719,   7'd73,  7'd88,  idle_cycles(eager));
        send_request(16'd720,   7'd73,  7'd88,  idle_cycles(eager));
        // all-ones and all-zeros fields
        send_request(16'hffff,  7'd100, 7'd100, idle_cycles(eager));
        send_request(16'hffff,  7'd127, 7'd127, idle_cycles(eager));
        send_request(16'd0,     7'd0,   7'd0,   idle_cycles(eager));
        // gray: no saturation
        send_request(16'd200,   7'd0,   7'd100, idle_cycles(eager));
        // saturation and brightness clamped to full scale
        send_request(16'd90,    7'd127, 7'd50,  idle_cycles(eager));
        send_request(16'd90,    7'd101, 7'd50,  idle_cycles(eager));
        send_request(16'd150,   7'd60,  7'd127, idle_cycles(eager));
        send_request(16'd270,   7'd60,  7'd101, idle_cycles(eager));
        // mid values and alternating bit patterns
        send_request(16'd30,    7'd50,  7'd80,  idle_cycles(eager));
        send_request(16'd43,    7'd1,   7'd1,   idle_cycles(eager));
        send_request(16'h5555,  7'h55,  7'h2a,  idle_cycles(eager));
        send_request(16'haaaa,  7'h2a,  7'h55,  idle_cycles(eager));

        // random part: idle habit changes every 40 requests, with a forced
        // back-to-back stretch around the sink's long hold-off
        for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) begin
                eager = ($urandom_range(0, 2) == 0);
            end
            send_request(rand_hue(), rand_pct(), rand_pct(),
                         idle_cycles(eager || (n >= BURST_FIRST && n <= BURST_LAST)));
        end
        s_valid <= 1'b0;

        // drain, then give any stray pixel time to show up
        do @(posedge aclk); while (sb.outstanding() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
